/* design/gsu_pkg.sv */
// Shared types and constants for the 2D GJK simplex update block.
package gsu_pkg;
	localparam int COORD_WIDTH = 16;
	localparam int PW = COORD_WIDTH + 1;   // point coordinate width
	localparam int DW = PW + 1;            // direction / edge coordinate width
	localparam int MW = 2 * DW + 1;        // dot product width

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_ADD   = 1'b1;

	typedef logic signed [PW-1:0] coord_t;
	typedef logic signed [DW-1:0] dcoord_t;
	typedef logic signed [MW-1:0] prod_t;

	typedef enum logic [2:0] {
		OP_LOAD,      // form point, do start or store
		OP_DOT_P,     // dot(dir, p)
		OP_CROSS,     // cross for edge or triangle sign
		OP_DOT_CO,    // first test against origin
		OP_DOT_CO2    // second test after swap
	} op_t;

	typedef struct packed {
		logic go;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic is_start;   // item reduces to a start
		logic neg;        // last product negative
		logic nonpos;     // last product <= 0
		logic two_pts;    // simplex holds two points after store
	} sts_t;
endpackage

/* design/gjk_simplex_update_2d.sv */
// Top level of the 2D GJK simplex update block.
// A request is accepted in a load step and then takes one dot or cross product per step on the
// single shared multiply-add unit (start and rejected add: one dot product; two-point add: dot
// and cross; triangle: dot, cross and one or two origin tests). A post step then writes the
// result into the output register, waiting while that register stays full and stalled.
// Results sit in that output register, and the next request is taken once the previous result
// is posted.
module gjk_simplex_update_2d (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // a_x, a_y, b_x, b_y
	input  logic        s_tuser,  // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // accepted, contains_origin, zero fill
);
	import gsu_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic busy, done, acc, set_flag, flag, in_fire, out_free;
	logic m_valid_q, acc_q, org_q;

	assign s_tready = !busy;
	assign in_fire = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	gsu_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .out_free, .sts, .cmd, .busy, .done, .acc, .set_flag
	);

	gsu_datapath u_dp (
		.clk, .arst_n, .cmd, .func(s_tuser),
		.a_x(s_tdata[15:0]), .a_y(s_tdata[31:16]),
		.b_x(s_tdata[47:32]), .b_y(s_tdata[63:48]),
		.set_flag, .sts, .flag
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			acc_q <= 1'b0;
			org_q <= 1'b0;
		end else begin
			if (done) begin
				m_valid_q <= 1'b1;
				acc_q <= acc;
				org_q <= flag;
			end else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {6'b0, org_q, acc_q};
endmodule

/* design/gsu_datapath.sv */
// Datapath: simplex storage, direction, one shared multiply-add unit.
module gsu_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gsu_pkg::cmd_t          cmd,
	input  logic                   func,
	input  logic [15:0]            a_x,
	input  logic [15:0]            a_y,
	input  logic [15:0]            b_x,
	input  logic [15:0]            b_y,
	input  logic                   set_flag,
	output gsu_pkg::sts_t          sts,
	output logic                   flag
);
	import gsu_pkg::*;

	coord_t  px_q [3];
	coord_t  py_q [3];
	logic [1:0] cnt_q;
	dcoord_t dx_q, dy_q;
	logic    flag_q;
	logic    s_q;      // sign of triangle cross: 1 positive, 0 negative/zero
	logic    z_q;      // cross was zero
	logic    start_q;

	coord_t  nx, ny;
	prod_t   m0, m1, r;
	dcoord_t ux, uy, vx, vy;
	logic    st;

	assign nx = coord_t'($signed(a_x[COORD_WIDTH-1:0])) - coord_t'($signed(b_x[COORD_WIDTH-1:0]));
	assign ny = coord_t'($signed(a_y[COORD_WIDTH-1:0])) - coord_t'($signed(b_y[COORD_WIDTH-1:0]));
	assign st = (func == FUNC_START) || (cnt_q == 2'd0);

	// newest point index
	logic [1:0] ip;
	assign ip = cnt_q - 2'd1;

	always_comb begin
		ux = '0; uy = '0; vx = '0; vy = '0;
		case (cmd.op)
			OP_DOT_P: begin
				ux = dx_q; uy = dy_q;
				vx = DW'(px_q[ip]); vy = DW'(py_q[ip]);
			end
			OP_CROSS: begin
				if (cnt_q == 2'd2) begin
					// cross(ab, d)
					ux = DW'(px_q[1]) - DW'(px_q[0]); uy = DW'(py_q[1]) - DW'(py_q[0]);
					vx = dy_q; vy = -dx_q;
				end else begin
					// cross(ca, cb)
					ux = DW'(px_q[0]) - DW'(px_q[2]); uy = DW'(py_q[0]) - DW'(py_q[2]);
					vx = DW'(py_q[1]) - DW'(py_q[2]); vy = -(DW'(px_q[1]) - DW'(px_q[2]));
				end
			end
			OP_DOT_CO, OP_DOT_CO2: begin
				ux = dx_q; uy = dy_q;
				vx = -DW'(px_q[2]); vy = -DW'(py_q[2]);
			end
			default: ;
		endcase
	end

	assign m0 = MW'(ux) * MW'(vx);
	assign m1 = MW'(uy) * MW'(vy);
	assign r  = m0 + m1;

	assign sts.is_start = start_q;
	assign sts.neg      = r[MW-1];
	assign sts.nonpos   = r[MW-1] || (r == '0);
	assign sts.two_pts  = (cnt_q == 2'd2);
	assign flag = flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			flag_q <= 1'b0;
			dx_q <= '0; dy_q <= '0;
			for (int i = 0; i < 3; i++) begin
				px_q[i] <= '0; py_q[i] <= '0;
			end
			s_q <= 1'b0; z_q <= 1'b0; start_q <= 1'b0;
		end else begin
			if (set_flag) flag_q <= 1'b1;
			if (cmd.go) begin
				case (cmd.op)
					OP_LOAD: begin
						start_q <= st;
						if (st) begin
							px_q[0] <= nx; py_q[0] <= ny;
							cnt_q <= 2'd1;
							dx_q <= -DW'(nx); dy_q <= -DW'(ny);
							flag_q <= (nx == '0) && (ny == '0);
						end else if (cnt_q == 2'd3) begin
							px_q[0] <= px_q[1]; py_q[0] <= py_q[1];
							px_q[1] <= px_q[2]; py_q[1] <= py_q[2];
							px_q[2] <= nx; py_q[2] <= ny;
						end else begin
							px_q[cnt_q] <= nx; py_q[cnt_q] <= ny;
							cnt_q <= cnt_q + 2'd1;
						end
					end
					OP_CROSS: begin
						s_q <= !r[MW-1] && (r != '0);
						z_q <= (r == '0);
						if (cnt_q == 2'd2) begin
							// dir = sgn * (-ab.y, ab.x)
							if (r == '0) begin
								dx_q <= '0; dy_q <= '0;
							end else if (!r[MW-1]) begin
								dx_q <= -(DW'(py_q[1]) - DW'(py_q[0]));
								dy_q <= DW'(px_q[1]) - DW'(px_q[0]);
							end else begin
								dx_q <= DW'(py_q[1]) - DW'(py_q[0]);
								dy_q <= -(DW'(px_q[1]) - DW'(px_q[0]));
							end
						end else begin
							if (r == '0) begin
								dx_q <= '0; dy_q <= '0;
							end else if (!r[MW-1]) begin
								dx_q <= -(DW'(py_q[1]) - DW'(py_q[2]));
								dy_q <= DW'(px_q[1]) - DW'(px_q[2]);
							end else begin
								dx_q <= DW'(py_q[1]) - DW'(py_q[2]);
								dy_q <= -(DW'(px_q[1]) - DW'(px_q[2]));
							end
						end
					end
					OP_DOT_CO: begin
						if (r[MW-1] || r == '0) begin
							// dir = -s * (-ca.y, ca.x); swap older points
							if (z_q) begin
								dx_q <= '0; dy_q <= '0;
							end else if (s_q) begin
								dx_q <= DW'(py_q[0]) - DW'(py_q[2]);
								dy_q <= -(DW'(px_q[0]) - DW'(px_q[2]));
							end else begin
								dx_q <= -(DW'(py_q[0]) - DW'(py_q[2]));
								dy_q <= DW'(px_q[0]) - DW'(px_q[2]);
							end
							px_q[0] <= px_q[1]; py_q[0] <= py_q[1];
							px_q[1] <= px_q[0]; py_q[1] <= py_q[0];
						end
					end
					default: ;
				endcase
			end
		end
	end
endmodule

/* design/gsu_ctrl.sv */
// Controller: sequences one request through the shared multiply-add unit.
module gsu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	input  logic           out_free,
	input  gsu_pkg::sts_t  sts,
	output gsu_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done,
	output logic           acc,
	output logic           set_flag
);
	import gsu_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_DOTP, S_CROSS, S_CO, S_CO2, S_DONE} state_t;
	state_t state_q;
	logic acc_q;

	assign busy = (state_q != S_IDLE);
	assign acc  = acc_q;

	always_comb begin
		cmd = '{go: 1'b0, op: OP_LOAD};
		done = 1'b0;
		set_flag = 1'b0;
		case (state_q)
			S_IDLE:  cmd = '{go: in_fire, op: OP_LOAD};
			S_DOTP:  cmd = '{go: 1'b1, op: OP_DOT_P};
			S_CROSS: begin
				cmd = '{go: 1'b1, op: OP_CROSS};
				set_flag = sts.two_pts && (sts.nonpos && !sts.neg);
			end
			S_CO:    cmd = '{go: 1'b1, op: OP_DOT_CO};
			S_CO2: begin
				cmd = '{go: 1'b1, op: OP_DOT_CO2};
				set_flag = sts.nonpos;
			end
			S_DONE:  done = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			acc_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) begin
					state_q <= S_DOTP;
					acc_q <= 1'b1;
				end
				S_DOTP: begin
					if (sts.is_start) state_q <= S_DONE;
					else if (sts.neg) begin
						acc_q <= 1'b0;
						state_q <= S_DONE;
					end else state_q <= S_CROSS;
				end
				S_CROSS: state_q <= sts.two_pts ? S_DONE : S_CO;
				S_CO:    state_q <= sts.nonpos ? S_CO2 : S_DONE;
				S_CO2:   state_q <= S_DONE;
				S_DONE:  if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* design/gsu_checker.sv */
// Port-level checker for the GJK simplex update block, bound to the top level.
module gsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:2] == 6'b0)
		else $error("fill bits set");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");
	// a new result only appears while a request is in flight
	a_post: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result posted with no request in flight");
endmodule

bind gjk_simplex_update_2d gsu_checker u_gsu_checker (
	.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

/* dv/tb_gjk_simplex_update_2d.sv */
// Self-checking stream testbench for the 2D GJK simplex update block.
`timescale 1ns / 100ps

module tb_gjk_simplex_update_2d;
	import gsu_pkg::*;

	typedef struct packed {
		logic        func;
		logic [15:0] a_x, a_y, b_x, b_y;
	} gjk_req_t;

	typedef struct packed {
		logic acc;
		logic orig;
	} gjk_res_t;

	localparam longint CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;

	gjk_simplex_update_2d uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	gjk_req_t req_q[$];
	gjk_res_t res_q[$];
	int       n_err = 0;
	int       n_res = 0;
	int       n_rej = 0;
	int       n_orig = 0;
	longint   cyc = 0;
	bit       hold_rx = 1'b0;
	bit       hold_go = 1'b0;
	bit       pause_tx = 1'b0;
	int       tx_gap = 0;
	int       rx_gap = 0;
	bit       sent_flag = 1'b0;

	// predictor state
	longint   pt_x[3], pt_y[3];
	int       pcount;
	longint   dx, dy;
	bit       oflag;

	function automatic longint sx16(logic [15:0] v);
		return longint'($signed(v));
	endfunction

	function automatic int sign64(longint v);
		return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
	endfunction

	function automatic int rand_gap();
		if ($urandom_range(0, 3) != 0) return 0;
		if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void seed_simplex(longint x, longint y);
		pt_x[0] = x; pt_y[0] = y;
		pcount = 1;
		dx = -x; dy = -y;
		oflag = (dx == 0 && dy == 0);
	endfunction

	function automatic gjk_res_t simplex_step(gjk_req_t r);
		longint   px, py, abx, aby, cax, cay, cbx, cby, tx, ty, k;
		int       s;
		gjk_res_t o;
		px = sx16(r.a_x) - sx16(r.b_x);
		py = sx16(r.a_y) - sx16(r.b_y);
		o.acc = 1'b1;
		if (r.func == FUNC_START || pcount == 0) begin
			seed_simplex(px, py);
		end else begin
			if (pcount >= 3) begin
				pt_x[0] = pt_x[1]; pt_y[0] = pt_y[1];
				pt_x[1] = pt_x[2]; pt_y[1] = pt_y[2];
				pt_x[2] = px; pt_y[2] = py;
			end else begin
				pt_x[pcount] = px; pt_y[pcount] = py;
				pcount++;
			end
			if (dx * px + dy * py < 0) begin
				o.acc = 1'b0;
			end else if (pcount == 2) begin
				abx = pt_x[1] - pt_x[0];
				aby = pt_y[1] - pt_y[0];
				s = sign64(abx * dy - aby * dx);
				dx = -s * aby; dy = s * abx;
				if (dx == 0 && dy == 0) oflag = 1'b1;
			end else begin
				cax = pt_x[0] - px; cay = pt_y[0] - py;
				cbx = pt_x[1] - px; cby = pt_y[1] - py;
				k = cax * cby - cay * cbx;
				s = sign64(k);
				dx = -s * cby; dy = s * cbx;
				if (dx * -px + dy * -py <= 0) begin
					dx = s * cay; dy = -s * cax;
					tx = pt_x[0]; ty = pt_y[0];
					pt_x[0] = pt_x[1]; pt_y[0] = pt_y[1];
					pt_x[1] = tx; pt_y[1] = ty;
					if (dx * -px + dy * -py <= 0) oflag = 1'b1;
				end
			end
		end
		o.orig = oflag;
		return o;
	endfunction

	function automatic gjk_req_t mk_req(bit f, int ax, int ay, int bx, int by);
		gjk_req_t r;
		r.func = f ? FUNC_ADD : FUNC_START;
		r.a_x = ax[15:0]; r.a_y = ay[15:0]; r.b_x = bx[15:0]; r.b_y = by[15:0];
		return r;
	endfunction

	function automatic int rcoord(int span);
		if ($urandom_range(0, 7) == 0) return int'($urandom) & 32'hFFFF;
		return $urandom_range(0, 2 * span) - span;
	endfunction

	task automatic queue_req(gjk_req_t r);
		req_q = {req_q, r};
	endtask

	// accepted requests go through the predictor
	always @(posedge clk) begin
		gjk_res_t pr;
		if (arst_n && s_tvalid && s_tready) begin
			pr = simplex_step(req_q.pop_front());
			res_q = {res_q, pr};
		end
		sent_flag <= arst_n && s_tvalid && s_tready;
	end

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !sent_flag) begin
				// hold current request
			end else if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				s_tvalid <= 1'b0;
			end else if (req_q.size() > 0 && !pause_tx) begin
				s_tvalid <= 1'b1;
				s_tuser <= req_q[0].func;
				s_tdata <= {req_q[0].b_y, req_q[0].b_x, req_q[0].a_y, req_q[0].a_x};
				tx_gap <= rand_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		gjk_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			n_res++;
			if (res_q.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("unexpected result %b", m_tdata[1:0]);
			end else begin
				e = res_q.pop_front();
				if (!e.acc) n_rej++;
				if (e.orig) n_orig++;
				if (m_tdata[0] !== e.acc || m_tdata[1] !== e.orig || m_tdata[7:2] !== '0) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch at result %0d: acc exp %b got %b, origin exp %b got %b",
							n_res, e.acc, m_tdata[0], e.orig, m_tdata[1]);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (hold_rx) begin
			m_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			rx_gap <= rand_gap();
		end
	end

	// long receiver hold-off, counted here while the sender keeps offering
	initial begin
		wait (hold_go);
		@(negedge clk) hold_rx = 1'b1;
		repeat (300) @(posedge clk);
		@(negedge clk) hold_rx = 1'b0;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cyc);
			$display("** gjk_simplex_update_2d: FAILED **");
			$finish;
		end
	end

	task automatic push_chain(int span);
		int n;
		queue_req(mk_req(0, rcoord(span), rcoord(span), rcoord(span), rcoord(span)));
		n = $urandom_range(1, 6);
		repeat (n) begin
			if ($urandom_range(0, 9) == 0)
				queue_req(mk_req(1, 0, 0, 0, 0));
			else
				queue_req(mk_req(1, rcoord(span), rcoord(span), rcoord(span),
					rcoord(span)));
		end
	endtask

	initial begin
		int sp;
		pt_x = '{0, 0, 0}; pt_y = '{0, 0, 0};
		pcount = 0; dx = 0; dy = 0; oflag = 1'b0;
		// directed: add to empty, extremes, origin start, collinear, triangle around origin
		queue_req(mk_req(1, 5, 3, 1, 1));
		queue_req(mk_req(0, 0, 0, 0, 0));
		queue_req(mk_req(1, 7, 7, 7, 7));
		queue_req(mk_req(0, 32767, 32767, -32768, -32768));
		queue_req(mk_req(1, -32768, -32768, 32767, 32767));
		queue_req(mk_req(1, 32767, -32768, -32768, 32767));
		queue_req(mk_req(1, -32768, 32767, 32767, -32768));
		queue_req(mk_req(0, 4, 0, 0, 0));
		queue_req(mk_req(1, 8, 0, 0, 0));
		queue_req(mk_req(0, 2, 0, 0, 0));
		queue_req(mk_req(1, -2, 0, 0, 0));
		queue_req(mk_req(1, 5, 0, 0, 0));
		queue_req(mk_req(0, 10, 0, 0, 0));
		queue_req(mk_req(1, -5, 5, 0, 0));
		queue_req(mk_req(1, -5, -5, 0, 0));
		queue_req(mk_req(1, 3, 3, 0, 0));
		queue_req(mk_req(0, 1, 1, 0, 0));
		queue_req(mk_req(1, -1, -1, 0, 0));
		queue_req(mk_req(0, -32768, 0, 32767, 0));
		queue_req(mk_req(1, 32767, 1, -32768, 0));
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		wait (req_q.size() == 0 && res_q.size() == 0);
		// random chains, mostly small coordinates
		while (req_q.size() < 800) begin
			sp = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(2, 20);
			push_chain(sp);
		end
		hold_go = 1'b1;
		wait (req_q.size() == 0);
		// sender pauses until every result is in
		pause_tx = 1'b1;
		wait (res_q.size() == 0);
		pause_tx = 1'b0;
		while (req_q.size() < 880) begin
			sp = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(2, 20);
			push_chain(sp);
		end
		wait (req_q.size() == 0 && res_q.size() == 0);
		repeat (20) @(posedge clk);
		$display("covered %0d results: %0d rejected points, %0d with origin enclosed",
			n_res, n_rej, n_orig);
		if (n_err == 0 && res_q.size() == 0) begin
			$display("** gjk_simplex_update_2d: PASSED **");
		end else begin
			$display("%0d mismatches", n_err);
			$display("** gjk_simplex_update_2d: FAILED **");
		end
		$finish;
	end
endmodule

/* gjk_simplex_update_2d.f */
design/gsu_pkg.sv
design/gsu_datapath.sv
design/gsu_ctrl.sv
design/gjk_simplex_update_2d.sv
design/gsu_checker.sv
dv/tb_gjk_simplex_update_2d.sv
